### hw/rtl/iprbc_pkg.sv
`default_nettype none

package iprbc_pkg;

   localparam int unsigned PROTO_W   = 8;
   localparam int unsigned RULE_W    = 8;
   localparam int unsigned VERDICT_W = 64;
   localparam int unsigned BIT_IDX_W = $clog2(VERDICT_W);
   localparam int unsigned TBL_DEPTH = 1 << PROTO_W;

   // rule bits at or above this count are rejected
   localparam logic [RULE_W-1:0] RULE_COUNT = RULE_W'(64);

   typedef enum logic [1:0] {
      MODE_SEARCH = 2'd0,
      MODE_ADD    = 2'd1,
      MODE_DELETE = 2'd2,
      MODE_RSVD   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_NONE    = 2'd2,
      STATUS_RSVD    = 2'd3
   } status_type;

   // write-back command from the rule update logic
   typedef struct packed {
      logic                 tbl_we;
      logic                 dflt_we;
      logic [VERDICT_W-1:0] data;
   } wr_cmd_type;

endpackage

`default_nettype wire

### hw/rtl/iprbc_table.sv
`default_nettype none

module iprbc_table (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            rd_en,
   input  wire  [iprbc_pkg::PROTO_W-1:0]   rd_addr,
   input  wire                            wr_en,
   input  wire  [iprbc_pkg::PROTO_W-1:0]   wr_addr,
   input  wire  [iprbc_pkg::VERDICT_W-1:0] wr_data,
   output logic [iprbc_pkg::VERDICT_W-1:0] rd_entry
);
   import iprbc_pkg::*;

   logic [VERDICT_W-1:0] mem [TBL_DEPTH];
   logic [TBL_DEPTH-1:0] valid_ff;
   logic [TBL_DEPTH-1:0] valid_in;
   logic [VERDICT_W-1:0] rd_raw_ff;
   logic                 rd_valid_ff;
   logic                 byp_ff;
   logic                 byp_in;
   logic [VERDICT_W-1:0] byp_data_ff;

   // a write landing in the same cycle as the read wins over the stale array word
   assign byp_in = wr_en && (wr_addr == rd_addr);

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_raw_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
         byp_ff      <= byp_in;
         byp_data_ff <= wr_data;
      end
   end

   // never-written entries read as empty
   assign rd_entry = byp_ff      ? byp_data_ff :
                     rd_valid_ff ? rd_raw_ff   : '0;

endmodule

`default_nettype wire

### hw/rtl/iprbc_rule_alu.sv
`default_nettype none

module iprbc_rule_alu (
   input  wire  [1:0]                      mode,
   input  wire  [iprbc_pkg::RULE_W-1:0]    rule_index,
   input  wire                             protocol_any,
   input  wire  [iprbc_pkg::VERDICT_W-1:0] verdict_in,
   input  wire  [iprbc_pkg::VERDICT_W-1:0] entry,
   input  wire  [iprbc_pkg::VERDICT_W-1:0] default_rules,
   input  wire                             learn_mode,
   output logic [1:0]                      status,
   output logic [iprbc_pkg::VERDICT_W-1:0] verdict_out,
   output iprbc_pkg::wr_cmd_type           wr_cmd
);
   import iprbc_pkg::*;

   logic [VERDICT_W-1:0] slot;
   logic [VERDICT_W-1:0] rule_bit;
   logic                 rule_ok;

   assign slot     = protocol_any ? default_rules : entry;
   assign rule_bit = VERDICT_W'(1) << rule_index[BIT_IDX_W-1:0];
   assign rule_ok  = rule_index < RULE_COUNT;

   always_comb begin
      status         = STATUS_OK;
      verdict_out    = verdict_in;
      wr_cmd.tbl_we  = 1'b0;
      wr_cmd.dflt_we = 1'b0;
      wr_cmd.data    = slot | rule_bit;
      unique case (mode)
         MODE_SEARCH: begin
            if (entry != '0) begin
               verdict_out = verdict_in & entry;
            end else if (learn_mode) begin
               verdict_out = '0;
            end else begin
               verdict_out = verdict_in & default_rules;
            end
         end
         MODE_ADD: begin
            if (!rule_ok) begin
               status = STATUS_INVALID;
            end else begin
               wr_cmd.tbl_we  = !protocol_any;
               wr_cmd.dflt_we = protocol_any;
            end
         end
         MODE_DELETE: begin
            wr_cmd.data = slot & ~rule_bit;
            if (!rule_ok) begin
               status = STATUS_INVALID;
            end else if ((slot & rule_bit) == '0) begin
               status = STATUS_NONE;
            end else begin
               wr_cmd.tbl_we  = !protocol_any;
               wr_cmd.dflt_we = protocol_any;
            end
         end
         default: begin
            status = STATUS_INVALID;
         end
      endcase
   end

endmodule

`default_nettype wire

### hw/rtl/ip_protocol_rule_bitmap_classifier.sv
// IP protocol rule bitmap classifier: the protocol field stage of a bit-vector
// packet classifier. One 64-bit rule bitmap per IP protocol number plus one
// default bitmap for "any protocol".
// req channel: one transfer per operation. tuser selects search, add or delete
//   (and the default bitmap for add/delete); tdata carries the rule index, the
//   protocol number and the incoming verdict.
// rsp channel: exactly one transfer per request, in order, carrying the status
//   and the verdict (search result, or the input verdict for add/delete).
// csr channel: writes learn mode; always ready. Write it only while idle.
// Throughput: one request per cycle while rsp_tready is high, including
//   back-to-back updates to the same protocol (the table write is forwarded
//   to the following read). Request to response: the table read registers with
//   the request into the working stage, and the update logic then feeds the
//   result register once that register is free or draining.
// Reset: the whole table and the default bitmap read as empty at once (per-entry
//   valid bits, no clearing pass); learn mode clears to 0.
// Stall: when rsp_tready is low the result register holds, the working stage
//   holds behind it, and req_tready drops only once both are full.
`default_nettype none

module ip_protocol_rule_bitmap_classifier (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // rule_index[7:0], protocol[15:8], verdict_in[79:16]
   input  wire  [79:0] req_tdata,
   // mode[1:0], protocol_any[2]
   input  wire  [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // verdict_out[63:0]
   output logic [63:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]  rsp_tuser,
   input  wire         csr_valid,
   output logic        csr_ready,
   // learn_mode[0]
   input  wire         csr_data
);
   import iprbc_pkg::*;

   logic                 req_fire;
   logic                 s1_fire;
   logic                 rsp_load;

   // working stage: the accepted request, table read in flight
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   logic [1:0]           s1_mode_ff;
   logic [RULE_W-1:0]    s1_rule_ff;
   logic [PROTO_W-1:0]   s1_proto_ff;
   logic                 s1_any_ff;
   logic [VERDICT_W-1:0] s1_verdict_ff;

   logic                 learn_ff;
   logic [VERDICT_W-1:0] dflt_ff;

   logic [VERDICT_W-1:0] entry;
   logic [1:0]           alu_status;
   logic [VERDICT_W-1:0] alu_verdict;
   wr_cmd_type           wr_cmd;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [1:0]           rsp_status_ff;
   logic [VERDICT_W-1:0] rsp_verdict_ff;

   // advance the working stage whenever the result register is free or draining
   assign rsp_load   = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && rsp_load;
   assign req_tready = !s1_valid_ff || rsp_load;
   assign req_fire   = req_tvalid && req_tready;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !s1_fire);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         learn_ff     <= 1'b0;
         dflt_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            learn_ff <= csr_data;
         end
         // updates commit only as the request leaves the working stage
         if (s1_fire && wr_cmd.dflt_we) begin
            dflt_ff <= wr_cmd.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_mode_ff    <= req_tuser[1:0];
         s1_any_ff     <= req_tuser[2];
         s1_rule_ff    <= req_tdata[7:0];
         s1_proto_ff   <= req_tdata[15:8];
         s1_verdict_ff <= req_tdata[79:16];
      end
      if (s1_fire) begin
         rsp_status_ff  <= alu_status;
         rsp_verdict_ff <= alu_verdict;
      end
   end

   iprbc_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_fire),
      .rd_addr  (req_tdata[15:8]),
      .wr_en    (s1_fire && wr_cmd.tbl_we),
      .wr_addr  (s1_proto_ff),
      .wr_data  (wr_cmd.data),
      .rd_entry (entry)
   );

   iprbc_rule_alu u_alu (
      .mode          (s1_mode_ff),
      .rule_index    (s1_rule_ff),
      .protocol_any  (s1_any_ff),
      .verdict_in    (s1_verdict_ff),
      .entry         (entry),
      .default_rules (dflt_ff),
      .learn_mode    (learn_ff),
      .status        (alu_status),
      .verdict_out   (alu_verdict),
      .wr_cmd        (wr_cmd)
   );

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_verdict_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

### hw/rtl/iprbc_checker.sv
`default_nettype none

module iprbc_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [63:0] rsp_tdata,
   input wire [1:0]  rsp_tuser
);
   import iprbc_pkg::*;

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != STATUS_RSVD)
      else $error("reserved status code");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // an empty result register means the working stage can always drain
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty result register");

endmodule

bind ip_protocol_rule_bitmap_classifier iprbc_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
